// ----- rtl/kclc_pkg.sv -----
`default_nettype none

package kclc_pkg;

	localparam int CODE_DIGITS = 4;
	localparam int CODE_W      = 4 * CODE_DIGITS;
	localparam int CNT_W       = $clog2(CODE_DIGITS + 1);

	// action codes
	localparam logic [1:0] ACT_KEY    = 2'd0;
	localparam logic [1:0] ACT_BUTTON = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	// key codes
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_ONE       = 4'd1;
	localparam logic [3:0] KEY_A         = 4'd10;
	localparam logic [3:0] KEY_B         = 4'd11;
	localparam logic [3:0] KEY_STAR      = 4'd14;
	localparam logic [3:0] KEY_HASH      = 4'd15;

	// lock modes
	localparam logic [1:0] MODE_LOCKED = 2'd0;
	localparam logic [1:0] MODE_OPEN   = 2'd1;
	localparam logic [1:0] MODE_CHANGE = 2'd2;
	localparam logic [1:0] MODE_FROZEN = 2'd3;

	// event codes
	localparam logic [3:0] EV_NONE         = 4'd0;
	localparam logic [3:0] EV_UNLOCKED     = 4'd1;
	localparam logic [3:0] EV_WRONG        = 4'd2;
	localparam logic [3:0] EV_FREEZE_START = 4'd3;
	localparam logic [3:0] EV_FREEZE_END   = 4'd4;
	localparam logic [3:0] EV_CHANGED      = 4'd5;
	localparam logic [3:0] EV_TOO_SHORT    = 4'd6;
	localparam logic [3:0] EV_AUTOLOCK     = 4'd7;
	localparam logic [3:0] EV_LOCKED       = 4'd8;

	// register indexes
	localparam logic [1:0] REG_AUTO_LOCK = 2'd0;
	localparam logic [1:0] REG_FREEZE    = 2'd1;
	localparam logic [1:0] REG_MAX_WRONG = 2'd2;

	localparam logic [6:0] AUTO_LOCK_RST = 7'd3;
	localparam logic [6:0] FREEZE_RST    = 7'd10;
	localparam logic [2:0] MAX_WRONG_RST = 3'd3;
	localparam logic [6:0] TICK_SAT      = 7'd127;
	localparam logic [2:0] MISS_SAT      = 3'd7;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] key_code;
	} req_t;

	typedef struct packed {
		logic [1:0] lock_mode;
		logic       bolt_open;
		logic [3:0] event_code;
		logic [2:0] digits_entered;
		logic [2:0] tries_wrong;
		logic       show_digits;
	} res_t;

	function automatic logic [CODE_W-1:0] reset_code();
		logic [CODE_W-1:0] c;
		c = '0;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			c = CODE_W'({c, 4'((i + 1) % 10)});
		end
		return c;
	endfunction

	localparam logic [CODE_W-1:0] CODE_RST = reset_code();

endpackage

`default_nettype wire

// ----- rtl/keypad_code_lock_controller_unit.sv -----
`default_nettype none

// Keypad code lock: takes key presses, a mode button and timer ticks, and
// returns one status result per request showing the lock state after it.
// A request is taken into an input register, and the whole state update
// runs from it into the result register when that register is free or its
// output is not stalled, so a new request can be taken every cycle unless
// the input is stalled. The result register stalls the input only when
// both are full and the output is stalled. Configuration writes are
// always ready and must be made while idle.
module keypad_code_lock_controller_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  kclc_pkg::req_t   req_data,
	output logic             res_valid,
	input  wire              res_stall,
	output kclc_pkg::res_t   res_data,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [1:0]        cfg_index,
	input  wire [6:0]        cfg_data
);
	import kclc_pkg::*;

	req_t              req_s1;
	logic              req_vld_s1;
	res_t              res_s2;
	logic              res_vld_s2;

	logic [6:0]        auto_lock_q;
	logic [6:0]        freeze_ticks_q;
	logic [2:0]        max_wrong_q;

	logic [1:0]        mode_q, mode_d;
	logic [CODE_W-1:0] stored_q, stored_d;
	logic [CODE_W-1:0] entry_q, entry_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [2:0]        miss_q, miss_d;
	logic [6:0]        freeze_q, freeze_d;
	logic [6:0]        relock_q, relock_d;
	logic              armed_q, armed_d;
	logic              visible_q, visible_d;
	logic [3:0]        ev_d;

	logic              advance;
	logic              take_req;
	logic              full_entry;

	assign advance   = req_vld_s1 && (!res_vld_s2 || !res_stall);
	assign req_stall = req_vld_s1 && !advance;
	assign take_req  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_vld_s2;
	assign res_data  = res_s2;
	assign full_entry = (count_q == CNT_W'(CODE_DIGITS));

	always_comb begin
		mode_d    = mode_q;
		stored_d  = stored_q;
		entry_d   = entry_q;
		count_d   = count_q;
		miss_d    = miss_q;
		freeze_d  = freeze_q;
		relock_d  = relock_q;
		armed_d   = armed_q;
		visible_d = visible_q;
		ev_d      = EV_NONE;
		case (req_s1.action)
			ACT_KEY: begin
				case (mode_q)
					MODE_LOCKED, MODE_CHANGE: begin
						if (req_s1.key_code <= KEY_DIGIT_MAX) begin
							if (!full_entry) begin
								entry_d = CODE_W'({entry_q, req_s1.key_code});
								count_d = count_q + CNT_W'(1);
							end
						end else if (req_s1.key_code == KEY_A) begin
							entry_d = '0;
							count_d = '0;
						end else if (req_s1.key_code == KEY_B) begin
							visible_d = !visible_q;
						end else if (req_s1.key_code == KEY_STAR) begin
							if (mode_q == MODE_CHANGE) begin
								entry_d = '0;
								count_d = '0;
								mode_d  = MODE_OPEN;
							end
						end else if (req_s1.key_code == KEY_HASH) begin
							entry_d = '0;
							count_d = '0;
							if (mode_q == MODE_LOCKED) begin
								if (full_entry && entry_q == stored_q) begin
									mode_d   = MODE_OPEN;
									relock_d = '0;
									armed_d  = 1'b1;
									ev_d     = EV_UNLOCKED;
								end else begin
									miss_d = (miss_q < MISS_SAT) ? miss_q + 3'd1 : miss_q;
									if (miss_d >= max_wrong_q) begin
										mode_d   = MODE_FROZEN;
										freeze_d = '0;
										ev_d     = EV_FREEZE_START;
									end else begin
										ev_d = EV_WRONG;
									end
								end
							end else if (!full_entry) begin
								ev_d = EV_TOO_SHORT;
							end else begin
								stored_d = entry_q;
								mode_d   = MODE_OPEN;
								armed_d  = 1'b1;
								relock_d = '0;
								ev_d     = EV_CHANGED;
							end
						end
					end
					MODE_OPEN: begin
						if (req_s1.key_code == KEY_STAR) begin
							mode_d   = MODE_LOCKED;
							entry_d  = '0;
							count_d  = '0;
							miss_d   = '0;
							relock_d = '0;
							armed_d  = 1'b0;
							ev_d     = EV_LOCKED;
						end else if (req_s1.key_code == KEY_ONE) begin
							mode_d  = MODE_CHANGE;
							entry_d = '0;
							count_d = '0;
							armed_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			ACT_BUTTON: begin
				if (mode_q == MODE_LOCKED) begin
					mode_d   = MODE_OPEN;
					entry_d  = '0;
					count_d  = '0;
					relock_d = '0;
					armed_d  = 1'b1;
					ev_d     = EV_UNLOCKED;
				end else if (mode_q == MODE_OPEN || mode_q == MODE_CHANGE) begin
					mode_d   = MODE_LOCKED;
					entry_d  = '0;
					count_d  = '0;
					miss_d   = '0;
					relock_d = '0;
					armed_d  = 1'b0;
					ev_d     = EV_LOCKED;
				end
			end
			ACT_TICK: begin
				if (mode_q == MODE_FROZEN) begin
					freeze_d = (freeze_q < TICK_SAT) ? freeze_q + 7'd1 : freeze_q;
					if (freeze_d >= freeze_ticks_q) begin
						mode_d   = MODE_LOCKED;
						entry_d  = '0;
						count_d  = '0;
						miss_d   = '0;
						freeze_d = '0;
						ev_d     = EV_FREEZE_END;
					end
				end else if (mode_q == MODE_OPEN && armed_q) begin
					relock_d = (relock_q < TICK_SAT) ? relock_q + 7'd1 : relock_q;
					if (relock_d >= auto_lock_q) begin
						mode_d   = MODE_LOCKED;
						entry_d  = '0;
						count_d  = '0;
						miss_d   = '0;
						relock_d = '0;
						armed_d  = 1'b0;
						ev_d     = EV_AUTOLOCK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1     <= 1'b0;
			res_vld_s2     <= 1'b0;
			auto_lock_q    <= AUTO_LOCK_RST;
			freeze_ticks_q <= FREEZE_RST;
			max_wrong_q    <= MAX_WRONG_RST;
			mode_q         <= MODE_LOCKED;
			stored_q       <= CODE_RST;
			entry_q        <= '0;
			count_q        <= '0;
			miss_q         <= '0;
			freeze_q       <= '0;
			relock_q       <= '0;
			armed_q        <= 1'b0;
			visible_q      <= 1'b0;
		end else begin
			if (!req_stall) begin
				req_vld_s1 <= req_valid;
			end
			if (advance) begin
				res_vld_s2 <= 1'b1;
			end else if (!res_stall) begin
				res_vld_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_AUTO_LOCK: auto_lock_q    <= cfg_data;
					REG_FREEZE:    freeze_ticks_q <= cfg_data;
					REG_MAX_WRONG: max_wrong_q    <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			if (advance) begin
				mode_q    <= mode_d;
				stored_q  <= stored_d;
				entry_q   <= entry_d;
				count_q   <= count_d;
				miss_q    <= miss_d;
				freeze_q  <= freeze_d;
				relock_q  <= relock_d;
				armed_q   <= armed_d;
				visible_q <= visible_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			req_s1 <= req_data;
		end
		if (advance) begin
			res_s2.lock_mode      <= mode_d;
			res_s2.bolt_open      <= (mode_d == MODE_OPEN) || (mode_d == MODE_CHANGE);
			res_s2.event_code     <= ev_d;
			res_s2.digits_entered <= 3'(count_d);
			res_s2.tries_wrong    <= miss_d;
			res_s2.show_digits    <= visible_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/kclc_checker.sv -----
`default_nettype none

module kclc_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            res_valid,
	input wire            res_stall,
	input kclc_pkg::res_t res_data
);
	import kclc_pkg::*;

	// bolt follows mode
	a_bolt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.bolt_open ==
			(res_data.lock_mode == MODE_OPEN || res_data.lock_mode == MODE_CHANGE)))
		else $error("bolt_open does not match lock_mode");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.event_code == EV_UNLOCKED |->
			res_data.lock_mode == MODE_OPEN && res_data.digits_entered == 3'd0)
		else $error("unlock event with wrong state");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.event_code == EV_FREEZE_START |->
			res_data.lock_mode == MODE_FROZEN && res_data.digits_entered == 3'd0)
		else $error("freeze event with wrong state");

	a_relock: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_code == EV_LOCKED ||
			res_data.event_code == EV_AUTOLOCK || res_data.event_code == EV_FREEZE_END) |->
			res_data.lock_mode == MODE_LOCKED && res_data.tries_wrong == 3'd0)
		else $error("lock event with wrong state");

endmodule

bind keypad_code_lock_controller_unit kclc_checker u_kclc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire

// ----- dv/keypad_code_lock_controller_unit_tb.sv -----
`default_nettype none

module keypad_code_lock_controller_unit_tb;
	import kclc_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [3:0] KEY_C     = 4'd12;
	localparam logic [3:0] KEY_D     = 4'd13;
	localparam logic [1:0] REG_NONE  = 2'd3;
	localparam int         CYCLE_CAP = 200000;

	typedef struct packed {
		req_t req;
		res_t status;
	} pend_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req_data = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_t       res_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	keypad_code_lock_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// lock state as the predictor sees it
	logic [1:0]        cur_mode;
	logic [CODE_W-1:0] code_word;
	logic [CODE_W-1:0] entry_word;
	logic [2:0]        entry_n;
	logic [2:0]        miss_n;
	logic [6:0]        frz_n;
	logic [6:0]        relock_n;
	logic              relock_on;
	logic              show_on;
	logic [6:0]        cfg_auto;
	logic [6:0]        cfg_freeze;
	logic [2:0]        cfg_max;

	pend_t request_q[$];
	res_t  status_q[$];
	pend_t held;
	logic  req_taken = 1'b0;
	int    sent_n = 0;
	int    done_n = 0;
	int    bad = 0;
	int    clk_count = 0;
	wire   calm = (clk_count >= 300) && (clk_count < 800);

	function automatic void clear_entry();
		entry_word = '0;
		entry_n = '0;
	endfunction

	function automatic void push_digit(logic [3:0] d);
		if (entry_n < CODE_DIGITS) begin
			entry_word = CODE_W'({entry_word, d});
			entry_n++;
		end
	endfunction

	function automatic logic [3:0] open_lock();
		cur_mode = MODE_OPEN;
		clear_entry();
		relock_n = '0;
		relock_on = 1'b1;
		return EV_UNLOCKED;
	endfunction

	function automatic logic [3:0] close_lock(logic [3:0] ev);
		cur_mode = MODE_LOCKED;
		clear_entry();
		miss_n = '0;
		relock_n = '0;
		relock_on = 1'b0;
		return ev;
	endfunction

	function automatic res_t lock_status_after(req_t rq);
		res_t       st;
		logic [3:0] ev;
		logic [3:0] k;
		ev = EV_NONE;
		k = rq.key_code;
		case (rq.action)
			ACT_KEY: begin
				if (cur_mode == MODE_LOCKED) begin
					if (k <= KEY_DIGIT_MAX) push_digit(k);
					else if (k == KEY_A) clear_entry();
					else if (k == KEY_B) show_on = !show_on;
					else if (k == KEY_HASH) begin
						if (entry_n == CODE_DIGITS && entry_word == code_word) begin
							ev = open_lock();
						end else begin
							clear_entry();
							if (miss_n < MISS_SAT) miss_n++;
							if (miss_n >= cfg_max) begin
								cur_mode = MODE_FROZEN;
								frz_n = '0;
								ev = EV_FREEZE_START;
							end else begin
								ev = EV_WRONG;
							end
						end
					end
				end else if (cur_mode == MODE_OPEN) begin
					if (k == KEY_STAR) ev = close_lock(EV_LOCKED);
					else if (k == KEY_ONE) begin
						cur_mode = MODE_CHANGE;
						clear_entry();
						relock_on = 1'b0;
					end
				end else if (cur_mode == MODE_CHANGE) begin
					if (k <= KEY_DIGIT_MAX) push_digit(k);
					else if (k == KEY_A) clear_entry();
					else if (k == KEY_B) show_on = !show_on;
					else if (k == KEY_STAR) begin
						clear_entry();
						cur_mode = MODE_OPEN;
					end else if (k == KEY_HASH) begin
						if (entry_n < CODE_DIGITS) begin
							clear_entry();
							ev = EV_TOO_SHORT;
						end else begin
							code_word = entry_word;
							clear_entry();
							cur_mode = MODE_OPEN;
							relock_on = 1'b1;
							relock_n = '0;
							ev = EV_CHANGED;
						end
					end
				end
			end
			ACT_BUTTON: begin
				if (cur_mode == MODE_LOCKED) ev = open_lock();
				else if (cur_mode == MODE_OPEN || cur_mode == MODE_CHANGE)
					ev = close_lock(EV_LOCKED);
			end
			ACT_TICK: begin
				if (cur_mode == MODE_FROZEN) begin
					if (frz_n < TICK_SAT) frz_n++;
					if (frz_n >= cfg_freeze) begin
						cur_mode = MODE_LOCKED;
						clear_entry();
						miss_n = '0;
						frz_n = '0;
						ev = EV_FREEZE_END;
					end
				end else if (cur_mode == MODE_OPEN && relock_on) begin
					if (relock_n < TICK_SAT) relock_n++;
					if (relock_n >= cfg_auto) ev = close_lock(EV_AUTOLOCK);
				end
			end
			default: ;
		endcase
		st.lock_mode = cur_mode;
		st.bolt_open = (cur_mode == MODE_OPEN) || (cur_mode == MODE_CHANGE);
		st.event_code = ev;
		st.digits_entered = entry_n;
		st.tries_wrong = miss_n;
		st.show_digits = show_on;
		return st;
	endfunction

	task automatic send(logic [1:0] act, logic [3:0] key);
		pend_t p;
		p.req.action = act;
		p.req.key_code = key;
		p.status = lock_status_after(p.req);
		request_q.push_back(p);
		sent_n++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send(ACT_TICK, 4'd0);
	endtask

	task automatic send_random_digits(int n);
		repeat (n) send(ACT_KEY, 4'($urandom_range(9)));
	endtask

	task automatic drain();
		wait (done_n == sent_n);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(logic [1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_AUTO_LOCK: cfg_auto = val;
			REG_FREEZE:    cfg_freeze = val;
			REG_MAX_WRONG: cfg_max = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic reprogram(logic [6:0] auto_t, logic [6:0] frz_t, logic [6:0] max_t);
		drain();
		program_reg(REG_AUTO_LOCK, auto_t);
		program_reg(REG_FREEZE, frz_t);
		program_reg(REG_MAX_WRONG, max_t);
		@(posedge clk);
	endtask

	// mostly well-formed key sequences for the current mode, some noise
	task automatic lock_traffic();
		int pick;
		pick = $urandom_range(99);
		case (cur_mode)
			MODE_LOCKED: begin
				if (pick < 45) begin
					if (pick < 6) send(ACT_KEY, KEY_B);
					for (int i = CODE_DIGITS - 1; i >= 0; i--)
						send(ACT_KEY, code_word[4*i +: 4]);
					send(ACT_KEY, KEY_HASH);
				end else if (pick < 70) begin
					send_random_digits($urandom_range(5));
					if (pick < 50) send(ACT_KEY, KEY_A);
					send(ACT_KEY, KEY_HASH);
				end else if (pick < 80) begin
					send(ACT_BUTTON, 4'($urandom_range(15)));
				end else if (pick < 85) begin
					send_ticks(1);
				end else begin
					send(2'($urandom_range(3)), 4'($urandom_range(15)));
				end
			end
			MODE_OPEN: begin
				if (pick < 40) send_ticks($urandom_range(1, 4));
				else if (pick < 65) send(ACT_KEY, KEY_ONE);
				else if (pick < 75) send(ACT_KEY, KEY_STAR);
				else if (pick < 82) send(ACT_BUTTON, 4'($urandom_range(15)));
				else send(2'($urandom_range(3)), 4'($urandom_range(15)));
			end
			MODE_CHANGE: begin
				if (pick < 55) begin
					send_random_digits(CODE_DIGITS);
					send(ACT_KEY, KEY_HASH);
				end else if (pick < 68) begin
					send_random_digits($urandom_range(CODE_DIGITS - 1));
					send(ACT_KEY, KEY_HASH);
				end else if (pick < 76) begin
					send(ACT_KEY, KEY_STAR);
				end else if (pick < 82) begin
					send(ACT_BUTTON, 4'($urandom_range(15)));
				end else if (pick < 86) begin
					send_random_digits(CODE_DIGITS + 2);
					send(ACT_KEY, KEY_HASH);
				end else begin
					send(2'($urandom_range(3)), 4'($urandom_range(15)));
				end
			end
			default: begin
				if (pick < 80) send_ticks($urandom_range(1, 10));
				else send(2'($urandom_range(3)), 4'($urandom_range(15)));
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			status_q.push_back(held.status);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (arst_n && request_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
				held = request_q.pop_front();
				req_data <= held.req;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (status_q.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected status: mode=%0d bolt=%0d ev=%0d dig=%0d tries=%0d show=%0d",
						res_data.lock_mode, res_data.bolt_open, res_data.event_code,
						res_data.digits_entered, res_data.tries_wrong, res_data.show_digits);
			end else begin
				want = status_q.pop_front();
				done_n++;
				if (res_data.lock_mode !== want.lock_mode ||
						res_data.bolt_open !== want.bolt_open ||
						res_data.event_code !== want.event_code ||
						res_data.digits_entered !== want.digits_entered ||
						res_data.tries_wrong !== want.tries_wrong ||
						res_data.show_digits !== want.show_digits) begin
					bad++;
					if (bad <= 10) begin
						$display("status mismatch at request %0d", done_n);
						$display("  exp mode=%0d bolt=%0d ev=%0d dig=%0d tries=%0d show=%0d",
							want.lock_mode, want.bolt_open, want.event_code,
							want.digits_entered, want.tries_wrong, want.show_digits);
						$display("  got mode=%0d bolt=%0d ev=%0d dig=%0d tries=%0d show=%0d",
							res_data.lock_mode, res_data.bolt_open, res_data.event_code,
							res_data.digits_entered, res_data.tries_wrong, res_data.show_digits);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		clk_count++;
		if (clk_count >= CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		cur_mode = MODE_LOCKED;
		code_word = '0;
		for (int i = 0; i < CODE_DIGITS; i++)
			code_word = CODE_W'({code_word, 4'((i + 1) % 10)});
		clear_entry();
		miss_n = '0;
		frz_n = '0;
		relock_n = '0;
		relock_on = 1'b0;
		show_on = 1'b0;
		cfg_auto = 7'd3;
		cfg_freeze = 7'd10;
		cfg_max = 3'd3;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset settings
		send(ACT_KEY, KEY_B);
		send(ACT_KEY, 4'd0);
		send(ACT_KEY, 4'd9);
		send(ACT_KEY, KEY_A);
		send(ACT_KEY, KEY_C);
		send(ACT_KEY, KEY_D);
		send(ACT_KEY, KEY_STAR);
		send(ACT_SPARE, KEY_HASH);
		send(ACT_KEY, 4'd1);
		send(ACT_KEY, 4'd2);
		send(ACT_KEY, 4'd3);
		send(ACT_KEY, 4'd4);
		send(ACT_KEY, 4'd5);
		send(ACT_KEY, KEY_HASH);
		send_ticks(1);
		send(ACT_KEY, KEY_ONE);
		send(ACT_KEY, 4'd9);
		send(ACT_KEY, 4'd8);
		send(ACT_KEY, KEY_HASH);
		send(ACT_KEY, 4'd9);
		send(ACT_KEY, 4'd0);
		send(ACT_KEY, 4'd9);
		send(ACT_KEY, 4'd0);
		send(ACT_KEY, KEY_HASH);
		send_ticks(3);
		send(ACT_KEY, KEY_HASH);
		send(ACT_KEY, KEY_HASH);
		send(ACT_KEY, KEY_HASH);
		send(ACT_BUTTON, 4'd0);

		while (sent_n < 120) lock_traffic();
		drain();
		@(posedge clk);
		while (sent_n < 200) lock_traffic();

		reprogram(7'd0, 7'd1, 7'd1);
		while (sent_n < 380) lock_traffic();

		reprogram(7'd127, 7'd127, 7'd7);
		while (sent_n < 560) lock_traffic();

		reprogram(7'd1, 7'd0, 7'd0);
		while (sent_n < 720) lock_traffic();

		drain();
		program_reg(REG_NONE, 7'($urandom_range(127)));
		reprogram(7'($urandom_range(8)), 7'($urandom_range(1, 6)), 7'($urandom_range(1, 4)));
		while (sent_n < 900) lock_traffic();

		// upper data bits set on the narrow register
		reprogram(7'd5, 7'd3, 7'h7A);
		while (sent_n < 1050) lock_traffic();

		drain();
		repeat (10) @(posedge clk);
		if (bad == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
